@@ hdl/sht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the slot handle table.
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int ID_W = 64;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_TAKE     = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_PRESENT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SELECT = 2'd1,
    ST_READ   = 2'd2,
    ST_RESP   = 2'd3
  } state_t;

  // compare request broadcast to every cell on accept; live low means the
  // key matches nothing
  typedef struct packed {
    logic            en;
    logic            live;
    logic [ID_W-1:0] key;
  } cmp_t;

  // write request; only the selected cell acts on it
  typedef struct packed {
    logic            load;
    logic            clear;
    logic [ID_W-1:0] value;
  } wr_t;

endpackage

`default_nettype wire

@@ hdl/sht_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sht_cell
// One slot: holds a handle id, registers its match flag and passes the
// claim and index of the lowest match on to its upper neighbor.
// ----------------------------------------------------------------------------
module sht_cell #(
  parameter int unsigned       IDX_W      = 6,
  parameter logic [IDX_W-1:0]  SLOT_INDEX = '0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sht_pkg::cmp_t    cmp,
  input  wire sht_pkg::wr_t     wr,
  input  wire logic             claim_in,
  output logic                  claim_out,
  input  wire logic [IDX_W-1:0] idx_in,
  output logic [IDX_W-1:0]      idx_out
);

  logic [sht_pkg::ID_W-1:0] slot_id;
  logic                     hit;
  logic                     sel;

  // lowest matching cell wins: drop the hit if a lower cell already claimed
  assign sel       = hit & ~claim_in;
  assign claim_out = claim_in | hit;
  assign idx_out   = idx_in | (sel ? SLOT_INDEX : '0);

  // capture the match on accept, hold it for the rest of the word
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmp.en) begin
      hit <= cmp.live && (slot_id == cmp.key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id <= '0;
    end else if (sel && wr.clear) begin
      slot_id <= '0;
    end else if (sel && wr.load) begin
      slot_id <= wr.value;
    end
  end

endmodule

`default_nettype wire

@@ hdl/slot_handle_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_handle_table_top
// Fixed table of slots holding nonzero handle ids and opaque payloads, built
// as a row of compare cells with a payload memory beside it.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Word
//  -------   --------------   ---------------------------------------------
//  command   start / busy     operation, handle_id, payload_in
//  result    done (strobe)    status, assigned_id, payload_out
//
// A word is accepted at a rising edge with start high and busy low. Every
// cell compares its id with the key at that edge. The next cycle ripples the
// lowest hit through the cell row and updates ids and the handle counter;
// the cycle after that writes or reads the payload memory. done then rises
// in the response state, high for one cycle. A new word may be accepted in
// the done cycle; each word passes through the compare, select and payload
// memory steps in turn. Reset clears all ids, sets the counter to one and
// needs no clearing pass. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module slot_handle_table_top #(
  parameter int unsigned SLOT_COUNT    = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    operation,
  input  wire logic [sht_pkg::ID_W-1:0]      handle_id,
  input  wire logic [PAYLOAD_WIDTH-1:0]      payload_in,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [sht_pkg::ID_W-1:0]           assigned_id,
  output logic [PAYLOAD_WIDTH-1:0]           payload_out
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  sht_pkg::state_t state, state_next;

  // held command word
  sht_pkg::op_t              op_r;
  logic [PAYLOAD_WIDTH-1:0]  pay_r;

  // select results
  logic [IDX_W-1:0]          idx_r;
  logic                      store_r;
  logic                      take_ok_r;
  sht_pkg::status_t          status_r;
  logic [sht_pkg::ID_W-1:0]  assigned_r;
  logic [sht_pkg::ID_W-1:0]  next_handle;

  logic [PAYLOAD_WIDTH-1:0]  payload_mem [SLOT_COUNT];
  logic [PAYLOAD_WIDTH-1:0]  rd_data;

  logic                      accept;
  sht_pkg::op_t              op_in;
  sht_pkg::cmp_t             cmp;
  sht_pkg::wr_t              wr;
  logic [SLOT_COUNT:0]       claim;
  logic [IDX_W-1:0]          idx_chain [SLOT_COUNT+1];
  logic                      found;
  logic                      handle_zero;

  assign op_in  = sht_pkg::op_t'(operation);
  assign accept = start && !busy;

  // Broadcast the key on every accept: register hunts for a free slot
  // (id zero); the other operations never match id zero, so drop live there
  // and every cell clears its hit.
  always_comb begin
    cmp.en   = accept;
    cmp.live = (op_in == sht_pkg::OP_REGISTER) || (handle_id != '0);
    cmp.key  = (op_in == sht_pkg::OP_REGISTER) ? '0 : handle_id;
  end

  // ---- cell row ------------------------------------------------------------
  assign claim[0]     = 1'b0;
  assign idx_chain[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    sht_cell #(
      .IDX_W      (IDX_W),
      .SLOT_INDEX (IDX_W'(i))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmp       (cmp),
      .wr        (wr),
      .claim_in  (claim[i]),
      .claim_out (claim[i+1]),
      .idx_in    (idx_chain[i]),
      .idx_out   (idx_chain[i+1])
    );
  end

  assign found       = claim[SLOT_COUNT];
  assign handle_zero = (next_handle == '0);

  // ---- control -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    wr.load    = 1'b0;
    wr.clear   = 1'b0;
    wr.value   = next_handle;
    unique case (state)
      sht_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sht_pkg::ST_SELECT;
        end
      end
      sht_pkg::ST_SELECT: begin
        busy       = 1'b1;
        // load a fresh id into the lowest free slot, or free the matched slot
        wr.load    = (op_r == sht_pkg::OP_REGISTER) && !handle_zero;
        wr.clear   = (op_r == sht_pkg::OP_TAKE) || (op_r == sht_pkg::OP_RELEASE);
        state_next = sht_pkg::ST_READ;
      end
      sht_pkg::ST_READ: begin
        busy       = 1'b1;
        state_next = sht_pkg::ST_RESP;
      end
      sht_pkg::ST_RESP: begin
        done       = 1'b1;
        state_next = accept ? sht_pkg::ST_SELECT : sht_pkg::ST_IDLE;
      end
      default: begin
        state_next = sht_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- command hold --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_in;
      pay_r <= payload_in;
    end
  end

  // ---- select: status, counter advance -------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      next_handle <= sht_pkg::ID_W'(1);
      store_r     <= 1'b0;
      take_ok_r   <= 1'b0;
    end else if (state == sht_pkg::ST_SELECT) begin
      idx_r      <= idx_chain[SLOT_COUNT];
      store_r    <= 1'b0;
      take_ok_r  <= 1'b0;
      assigned_r <= '0;
      if (op_r == sht_pkg::OP_REGISTER) begin
        priority if (!found) begin
          status_r <= sht_pkg::STAT_FULL;
        end else if (handle_zero) begin
          // zero is never handed out: skip it, the counter moves on to one
          status_r    <= sht_pkg::STAT_EXHAUSTED;
          next_handle <= next_handle + sht_pkg::ID_W'(1);
        end else begin
          status_r    <= sht_pkg::STAT_OK;
          assigned_r  <= next_handle;
          store_r     <= 1'b1;
          next_handle <= next_handle + sht_pkg::ID_W'(1);
        end
      end else begin
        status_r  <= found ? sht_pkg::STAT_OK : sht_pkg::STAT_NOT_FOUND;
        take_ok_r <= found && (op_r == sht_pkg::OP_TAKE);
      end
    end
  end

  // ---- payload memory ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == sht_pkg::ST_READ) begin
      if (store_r) begin
        payload_mem[idx_r] <= pay_r;
      end
      rd_data <= payload_mem[idx_r];
    end
  end

  // ---- result --------------------------------------------------------------
  assign status      = status_r;
  assign assigned_id = assigned_r;
  assign payload_out = take_ok_r ? rd_data : '0;

  // ---- assertions ----------------------------------------------------------
  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing three cycles after accept");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_register_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == sht_pkg::STAT_OK) && (op_r == sht_pkg::OP_REGISTER))
      |-> (assigned_id != '0))
    else $error("successful register returned id zero");

  a_payload_only_on_take: assert property (@(posedge clk) disable iff (rst)
    (done && (op_r != sht_pkg::OP_TAKE)) |-> (payload_out == '0))
    else $error("payload returned by an operation other than take");

endmodule

`default_nettype wire

@@ test/slot_handle_table_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_handle_table_top_test
// Self-checking bench for the slot handle table: a directed walk over the
// corner cases, then random register / take / release / present traffic
// under several sender idle rates, all scored against a local table model.
// ----------------------------------------------------------------------------
module slot_handle_table_top_test;

  localparam int          SLOTS          = 64;
  localparam int          PAY_W          = 64;
  localparam int          ITEMS_PER_PASS = 460;
  localparam int          CYCLE_LIMIT    = 100000;
  localparam logic [63:0] ONES           = '1;

  // One result word as the block reports it.
  typedef struct packed {
    sht_pkg::status_t          status;
    logic [sht_pkg::ID_W-1:0]  assigned_id;
    logic [PAY_W-1:0]          payload_out;
  } result_t;

  // One row of the directed table. Rows with known set carry a result that
  // is typed in; the others take their result from the table model.
  typedef struct packed {
    sht_pkg::op_t              op;
    logic [sht_pkg::ID_W-1:0]  id;
    logic [PAY_W-1:0]          payload;
    logic                      known;
    result_t                   res;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [1:0]                operation = 2'd0;
  logic [sht_pkg::ID_W-1:0]  handle_id = '0;
  logic [PAY_W-1:0]          payload_in = '0;
  wire                       busy;
  wire                       done;
  wire [1:0]                 status;
  wire [sht_pkg::ID_W-1:0]   assigned_id;
  wire [PAY_W-1:0]           payload_out;

  // Local copy of the table: ids (zero = free slot), payloads and counter.
  logic [sht_pkg::ID_W-1:0]  held_ids [SLOTS];
  logic [PAY_W-1:0]          held_payloads [SLOTS];
  logic [sht_pkg::ID_W-1:0]  next_id;
  logic [sht_pkg::ID_W-1:0]  retired_id;

  result_t               pending_results [$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    gap_pct = 0;

  // Ids 1..6 are handed out in order by the directed rows; each row's result
  // follows from the rows above it.
  stim_row_t directed_rows [22] = '{
    '{sht_pkg::OP_PRESENT,  64'd0,  64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_TAKE,     64'd0,  64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_RELEASE,  ONES,   ONES,  1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_REGISTER, 64'd0,  ONES,  1'b1,
      '{sht_pkg::STAT_OK, 64'd1, 64'd0}},
    '{sht_pkg::OP_REGISTER, 64'd0,  64'd0, 1'b1,
      '{sht_pkg::STAT_OK, 64'd2, 64'd0}},
    '{sht_pkg::OP_REGISTER, 64'd0,  64'h8000_0000_0000_0001, 1'b1,
      '{sht_pkg::STAT_OK, 64'd3, 64'd0}},
    '{sht_pkg::OP_PRESENT,  64'd1,  64'd0, 1'b1,
      '{sht_pkg::STAT_OK, 64'd0, 64'd0}},
    // zero must not match the free slots either
    '{sht_pkg::OP_PRESENT,  64'd0,  64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_TAKE,     64'd1,  64'd0, 1'b1,
      '{sht_pkg::STAT_OK, 64'd0, ONES}},
    '{sht_pkg::OP_TAKE,     64'd1,  64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    // lowest free slot is slot 0 again
    '{sht_pkg::OP_REGISTER, 64'd0,  64'h5555_5555_5555_5555, 1'b1,
      '{sht_pkg::STAT_OK, 64'd4, 64'd0}},
    '{sht_pkg::OP_RELEASE,  64'd2,  64'd0, 1'b1,
      '{sht_pkg::STAT_OK, 64'd0, 64'd0}},
    '{sht_pkg::OP_PRESENT,  64'd2,  64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_TAKE,     64'd4,  64'd0, 1'b1,
      '{sht_pkg::STAT_OK, 64'd0, 64'h5555_5555_5555_5555}},
    '{sht_pkg::OP_TAKE,     64'd3,  64'd0, 1'b1,
      '{sht_pkg::STAT_OK, 64'd0, 64'h8000_0000_0000_0001}},
    '{sht_pkg::OP_RELEASE,  64'd3,  64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    // register ignores handle_id, take ignores payload_in
    '{sht_pkg::OP_REGISTER, ONES,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
      '{sht_pkg::STAT_OK, 64'd5, 64'd0}},
    '{sht_pkg::OP_PRESENT,  ONES,   64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_TAKE,     64'd5,  ONES,  1'b1,
      '{sht_pkg::STAT_OK, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA}},
    '{sht_pkg::OP_PRESENT,  64'h1_0000_0005, 64'd0, 1'b1,
      '{sht_pkg::STAT_NOT_FOUND, 64'd0, 64'd0}},
    '{sht_pkg::OP_REGISTER, 64'd0,  64'h0123_4567_89AB_CDEF, 1'b0,
      '{sht_pkg::STAT_OK, 64'd0, 64'd0}},
    '{sht_pkg::OP_TAKE,     64'd6,  64'd0, 1'b0,
      '{sht_pkg::STAT_OK, 64'd0, 64'd0}}
  };

  slot_handle_table_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .handle_id   (handle_id),
    .payload_in  (payload_in),
    .done        (done),
    .status      (status),
    .assigned_id (assigned_id),
    .payload_out (payload_out)
  );

  always #5 clk = ~clk;

  // Apply one word to the local table and return the result it produces.
  // Zero is never a match; the lowest matching slot wins.
  function automatic result_t table_apply(sht_pkg::op_t op,
                                          logic [sht_pkg::ID_W-1:0] id,
                                          logic [PAY_W-1:0] pay);
    result_t                   res;
    int                        hit;
    logic [sht_pkg::ID_W-1:0]  fresh;
    res  = '{sht_pkg::STAT_NOT_FOUND, '0, '0};
    hit  = -1;
    if (op == sht_pkg::OP_REGISTER) begin
      for (int i = SLOTS - 1; i >= 0; i--)
        if (held_ids[i] == '0) hit = i;
      if (hit < 0) begin
        res.status = sht_pkg::STAT_FULL;
      end else begin
        fresh   = next_id;
        next_id = next_id + sht_pkg::ID_W'(1);
        if (fresh == '0) begin
          res.status = sht_pkg::STAT_EXHAUSTED;
        end else begin
          held_ids[hit]      = fresh;
          held_payloads[hit] = pay;
          res.status         = sht_pkg::STAT_OK;
          res.assigned_id    = fresh;
        end
      end
    end else if (id != '0) begin
      for (int i = SLOTS - 1; i >= 0; i--)
        if (held_ids[i] == id) hit = i;
      if (hit >= 0) begin
        res.status = sht_pkg::STAT_OK;
        if (op == sht_pkg::OP_TAKE) res.payload_out = held_payloads[hit];
        if (op != sht_pkg::OP_PRESENT) begin
          retired_id         = held_ids[hit];
          held_ids[hit]      = '0;
          held_payloads[hit] = '0;
        end
      end
    end
    return res;
  endfunction

  // Mostly ids that are live right now, the rest zero, stale, not yet
  // issued or fully random.
  function automatic logic [sht_pkg::ID_W-1:0] pick_id();
    int r;
    int base;
    r    = $urandom_range(99);
    base = $urandom_range(SLOTS - 1);
    if (r < 70) begin
      for (int i = 0; i < SLOTS; i++)
        if (held_ids[(base + i) % SLOTS] != '0) return held_ids[(base + i) % SLOTS];
    end
    if (r < 78) return '0;
    if (r < 86) return retired_id;
    if (r < 90) return next_id;
    return {$urandom, $urandom};
  endfunction

  // Filling bursts push the table to full; draining bursts empty it again.
  function automatic sht_pkg::op_t pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 80) return sht_pkg::OP_REGISTER;
      if (r < 90) return sht_pkg::OP_TAKE;
      if (r < 95) return sht_pkg::OP_RELEASE;
      return sht_pkg::OP_PRESENT;
    end
    if (r < 20) return sht_pkg::OP_REGISTER;
    if (r < 55) return sht_pkg::OP_TAKE;
    if (r < 80) return sht_pkg::OP_RELEASE;
    return sht_pkg::OP_PRESENT;
  endfunction

  // Offer one word. Entered and left just after a falling edge, so start
  // stays high straight into the next word when no gap is drawn.
  task automatic send_word(sht_pkg::op_t op, logic [sht_pkg::ID_W-1:0] id,
                           logic [PAY_W-1:0] pay, bit known, result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    operation  = op;
    handle_id  = id;
    payload_in = pay;
    // hold the word until a rising edge sees busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = table_apply(op, id, pay);
    pending_results.push_back(known ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Score every result word against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d id %h payload %h",
                 $time, status, assigned_id, payload_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
          mismatch_count++;
        end
        if (assigned_id !== want.assigned_id) begin
          $display("%0t: assigned_id mismatch: expected %h, actual %h",
                   $time, want.assigned_id, assigned_id);
          mismatch_count++;
        end
        if (payload_out !== want.payload_out) begin
          $display("%0t: payload_out mismatch: expected %h, actual %h",
                   $time, want.payload_out, payload_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int pass_gap [4];
    pass_gap = '{0, 46, 0, 17};
    for (int i = 0; i < SLOTS; i++) begin
      held_ids[i]      = '0;
      held_payloads[i] = '0;
    end
    next_id    = 64'd1;
    retired_id = '0;

    // Hold reset, then drop it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk, back to back.
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].id, directed_rows[i].payload,
                directed_rows[i].known, directed_rows[i].res);

    // Random traffic: four passes under sender idle rates of 0, 46, 0 and 17
    // percent, each made of alternating fill and drain bursts so that table
    // full is hit many times. Ids exhausted and counter wrap need 2^64
    // registers and lie beyond any run.
    for (int p = 0; p < 4; p++) begin
      gap_pct = pass_gap[p];
      for (int n = 0; n < ITEMS_PER_PASS; n++)
        send_word(pick_op((n % 200) < 100), pick_id(), {$urandom, $urandom},
                  1'b0, '{sht_pkg::STAT_OK, 64'd0, 64'd0});
    end
    start = 1'b0;

    // Drain outstanding results, then let the pipeline settle.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
